### rtl/core/sha1c_pkg.sv
package sha1c_pkg;

    // Block geometry.
    localparam int unsigned BLOCK_WORDS  = 16;
    localparam int unsigned ROUND_COUNT  = 80;
    localparam int unsigned DIGEST_WORDS = 5;

    localparam int unsigned WORD_CNT_W  = $clog2(BLOCK_WORDS);
    localparam int unsigned ROUND_CNT_W = $clog2(ROUND_COUNT);
    localparam int unsigned DIGEST_IDX_W = $clog2(DIGEST_WORDS);

    // Round boundaries between the four round functions.
    localparam logic [ROUND_CNT_W-1:0] PARITY1_START  = ROUND_CNT_W'(20);
    localparam logic [ROUND_CNT_W-1:0] MAJORITY_START = ROUND_CNT_W'(40);
    localparam logic [ROUND_CNT_W-1:0] PARITY2_START  = ROUND_CNT_W'(60);
    localparam logic [ROUND_CNT_W-1:0] LAST_ROUND     = ROUND_CNT_W'(ROUND_COUNT - 1);
    localparam logic [ROUND_CNT_W-1:0] EXPAND_START   = ROUND_CNT_W'(BLOCK_WORDS);
    localparam logic [WORD_CNT_W-1:0]  LAST_WORD      = WORD_CNT_W'(BLOCK_WORDS - 1);
    localparam logic [DIGEST_IDX_W-1:0] LAST_DIGEST   = DIGEST_IDX_W'(DIGEST_WORDS - 1);

    // Initial chaining value.
    localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round function selector.
    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY1,
        PH_MAJORITY,
        PH_PARITY2
    } sha1c_phase_t;

    // Input request and result payloads.
    typedef struct packed {
        logic [31:0] data_word;
        logic        first_block;
        logic        final_block;
    } sha1c_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } sha1c_out_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic         load_word;
        logic         round_load;
        logic         round_step;
        logic         expand;
        sha1c_phase_t phase;
        logic         chain_init;
        logic         chain_update;
    } sha1c_ctl_t;

    // Round constant for each round function.
    function automatic logic [31:0] round_const(input sha1c_phase_t ph);
        logic [31:0] k;
        begin
            unique case (ph)
                PH_CHOOSE:   k = 32'h5A827999;
                PH_PARITY1:  k = 32'h6ED9EBA1;
                PH_MAJORITY: k = 32'h8F1BBCDC;
                PH_PARITY2:  k = 32'hCA62C1D6;
                default:     k = 32'h5A827999;
            endcase
            return k;
        end
    endfunction

endpackage

### rtl/core/sha1c_sched.sv
module sha1c_sched
    import sha1c_pkg::*;
(
    input  logic        clk,
    input  sha1c_ctl_t  ctl,
    input  logic [31:0] data_word,
    output logic [31:0] wt
);

    logic [31:0] win_reg [BLOCK_WORDS];
    logic [31:0] mix;
    logic [31:0] tail_next;

    // Expanded schedule word from the fixed taps of the window.
    assign mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign wt  = ctl.expand ? {mix[30:0], mix[31]} : win_reg[0];

    // Message words shift in while loading; round words shift in during rounds.
    assign tail_next = ctl.load_word ? data_word : wt;

    always_ff @(posedge clk)
    begin
        if (ctl.load_word || ctl.round_step)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[BLOCK_WORDS - 1] <= tail_next;
        end
    end

endmodule

### rtl/core/sha1c_round.sv
module sha1c_round
    import sha1c_pkg::*;
(
    input  logic        clk,
    input  sha1c_ctl_t  ctl,
    input  logic [31:0] load_val [DIGEST_WORDS],
    input  logic [31:0] wt,
    output logic [31:0] work [DIGEST_WORDS]
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] f;
    logic [31:0] temp_next;

    // Round function for the current phase.
    always_comb
    begin
        unique case (ctl.phase)
            PH_CHOOSE:   f = (b_reg & c_reg) | (~b_reg & d_reg);
            PH_MAJORITY: f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            PH_PARITY1,
            PH_PARITY2:  f = b_reg ^ c_reg ^ d_reg;
            default:     f = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    // The shared round adder; all sums wrap at 32 bits.
    assign temp_next = {a_reg[26:0], a_reg[31:27]} + f + e_reg
                       + round_const(ctl.phase) + wt;

    always_ff @(posedge clk)
    begin
        if (ctl.round_load)
        begin
            a_reg <= load_val[0];
            b_reg <= load_val[1];
            c_reg <= load_val[2];
            d_reg <= load_val[3];
            e_reg <= load_val[4];
        end
        else if (ctl.round_step)
        begin
            a_reg <= temp_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assign work[0] = a_reg;
    assign work[1] = b_reg;
    assign work[2] = c_reg;
    assign work[3] = d_reg;
    assign work[4] = e_reg;

endmodule

### rtl/core/sha1c_seq.sv
module sha1c_seq
    import sha1c_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    first_block,
    input  logic                    final_block,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [DIGEST_IDX_W-1:0] out_idx,
    output sha1c_ctl_t              ctl
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUTPUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [WORD_CNT_W-1:0]   word_cnt_reg, word_cnt_next;
    logic [ROUND_CNT_W-1:0]  round_cnt_reg, round_cnt_next;
    logic [DIGEST_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic                    final_reg, final_next;
    logic                    accept;
    logic                    block_done;

    assign in_ready   = (state_reg == ST_LOAD);
    assign out_valid  = (state_reg == ST_OUTPUT);
    assign out_idx    = out_idx_reg;
    assign accept     = in_valid && in_ready;
    assign block_done = accept && (word_cnt_reg == LAST_WORD);

    // Datapath controls decoded from the state.
    always_comb
    begin
        ctl              = '0;
        ctl.load_word    = accept;
        ctl.round_load   = block_done;
        ctl.chain_init   = block_done && first_block;
        ctl.round_step   = (state_reg == ST_ROUND);
        ctl.expand       = (state_reg == ST_ROUND) && (round_cnt_reg >= EXPAND_START);
        ctl.chain_update = (state_reg == ST_UPDATE);
        if (round_cnt_reg < PARITY1_START)
        begin
            ctl.phase = PH_CHOOSE;
        end
        else if (round_cnt_reg < MAJORITY_START)
        begin
            ctl.phase = PH_PARITY1;
        end
        else if (round_cnt_reg < PARITY2_START)
        begin
            ctl.phase = PH_MAJORITY;
        end
        else
        begin
            ctl.phase = PH_PARITY2;
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        round_cnt_next = round_cnt_reg;
        out_idx_next   = out_idx_reg;
        final_next     = final_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    word_cnt_next = word_cnt_reg + 1'b1;
                    if (block_done)
                    begin
                        final_next     = final_block;
                        round_cnt_next = '0;
                        state_next     = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                round_cnt_next = round_cnt_reg + 1'b1;
                if (round_cnt_reg == LAST_ROUND)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                out_idx_next = '0;
                state_next   = final_reg ? ST_OUTPUT : ST_LOAD;
            end
            ST_OUTPUT:
            begin
                if (out_ready)
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                    if (out_idx_reg == LAST_DIGEST)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            word_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            out_idx_reg   <= '0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            round_cnt_reg <= round_cnt_next;
            out_idx_reg   <= out_idx_next;
            final_reg     <= final_next;
        end
    end

endmodule

### rtl/core/sha1_block_compression.sv
// SHA-1 block compression core. Padded message words enter one per request,
// one per cycle, sixteen to a block; the flags of the sixteenth request decide
// whether the block restarts from the standard initial values and whether the
// five digest words h0..h4 are sent out afterwards. A single round unit runs
// the 80 rounds at one round per cycle, fed by a 16-word shift window that
// expands the message schedule. A block is loaded, run through the rounds and
// then added into the chaining value; after a final block the five digest
// words go out one by one, each held while the consumer stalls.
// The core does not take new words while it is compressing or emitting.
module sha1_block_compression
    import sha1c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       word_valid,
    output logic       word_ready,
    input  sha1c_in_t  word,
    output logic       digest_valid,
    input  logic       digest_ready,
    output sha1c_out_t digest
);

    sha1c_ctl_t              ctl;
    logic [DIGEST_IDX_W-1:0] out_idx;
    logic [31:0]             wt;
    logic [31:0]             chain_reg [DIGEST_WORDS];
    logic [31:0]             load_val [DIGEST_WORDS];
    logic [31:0]             work [DIGEST_WORDS];

    sha1c_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (word_valid),
        .in_ready    (word_ready),
        .first_block (word.first_block),
        .final_block (word.final_block),
        .out_valid   (digest_valid),
        .out_ready   (digest_ready),
        .out_idx     (out_idx),
        .ctl         (ctl)
    );

    sha1c_sched u_sched (
        .clk       (clk),
        .ctl       (ctl),
        .data_word (word.data_word),
        .wt        (wt)
    );

    sha1c_round u_round (
        .clk      (clk),
        .ctl      (ctl),
        .load_val (load_val),
        .wt       (wt),
        .work     (work)
    );

    // Working variables start from the initial values on a first block.
    always_comb
    begin
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            load_val[i] = ctl.chain_init ? INIT_HASH[i] : chain_reg[i];
        end
    end

    // Chaining value with feed-forward addition after the last round.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else if (ctl.chain_init)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else if (ctl.chain_update)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= chain_reg[i] + work[i];
            end
        end
    end

    // Digest words go out from the held chaining value.
    assign digest.digest_word = chain_reg[out_idx];
    assign digest.digest_last = (out_idx == LAST_DIGEST);

endmodule

### rtl/core/sha1c_checker.sv
module sha1c_checker
    import sha1c_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       word_valid,
    input logic       word_ready,
    input sha1c_in_t  word,
    input logic       digest_valid,
    input logic       digest_ready,
    input sha1c_out_t digest
);

    // The core never takes words while a digest is being sent.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(digest_valid && word_ready))
        else $error("word_ready high while digest is pending");

    // A digest burst continues until its last word is taken.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !digest.digest_last |=> digest_valid)
        else $error("digest burst ended early");

    // After the last word the burst is over.
    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && digest.digest_last |=> !digest_valid)
        else $error("digest continued past last word");

    // A burst starts only after compression, never straight from loading.
    a_burst_after_compress: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> $past(!word_ready))
        else $error("digest started while loading words");

    // A stalled digest request holds its payload.
    a_digest_stable: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest))
        else $error("stalled digest request changed");

endmodule

bind sha1_block_compression sha1c_checker u_sha1c_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .word         (word),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
);

### dv/sha1_digest_checker.sv
`timescale 1ns / 100ps

module sha1_digest_checker
    import sha1c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       word_valid,
    input  logic       word_ready,
    input  sha1c_in_t  word,
    input  logic       digest_valid,
    input  logic       digest_ready,
    input  sha1c_out_t digest,
    output int         fail_count,
    output int         digests_pending,
    output int         digests_checked
);

    localparam int unsigned REPORT_LIMIT = 10;

    // Predicted chaining value, collected message words and word position.
    logic [31:0]           chain [DIGEST_WORDS];
    logic [31:0]           window [BLOCK_WORDS];
    logic [WORD_CNT_W-1:0] word_index;
    sha1c_out_t            expected_digests [$];
    sha1c_out_t            wanted;
    int                    failures;
    int                    checked;
    int unsigned           idx;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Runs the 80 rounds over the collected block and feeds forward into the chain.
    function automatic void compress_into_chain();
        logic [31:0]  w [BLOCK_WORDS];
        logic [31:0]  a, b, c, d, e, f, k, t_sum;
        sha1c_phase_t phase;
        int unsigned  t;
        int unsigned  s;
        w = window;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (t = 0; t < ROUND_COUNT; t++)
        begin
            s = t % BLOCK_WORDS;
            // From round 16 on, the window slot is replaced by the expanded schedule word.
            if (t >= BLOCK_WORDS)
                w[s] = rotl32(w[(s + 13) % BLOCK_WORDS] ^ w[(s + 8) % BLOCK_WORDS]
                              ^ w[(s + 2) % BLOCK_WORDS] ^ w[s], 1);
            if (t < 20)
                phase = PH_CHOOSE;
            else if (t < 40)
                phase = PH_PARITY1;
            else if (t < 60)
                phase = PH_MAJORITY;
            else
                phase = PH_PARITY2;
            case (phase)
                PH_CHOOSE:
                begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end
                PH_PARITY1:
                begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end
                PH_MAJORITY:
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end
                default:
                begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
            endcase
            t_sum = rotl32(a, 5) + f + e + k + w[s];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t_sum;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        chain[4] = chain[4] + e;
    endfunction

    // Watch both channels, predict on each request and check each digest word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (idx = 0; idx < DIGEST_WORDS; idx++)
                chain[idx] = INIT_HASH[idx];
            word_index = '0;
            expected_digests.delete();
            failures = 0;
            checked = 0;
            fail_count <= 0;
            digests_pending <= 0;
            digests_checked <= 0;
        end
        else
        begin
            // Compare an accepted digest word with the oldest prediction.
            if (digest_valid && digest_ready)
            begin
                if (expected_digests.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("sha1 check: digest word %h (last %b) with nothing pending",
                                 digest.digest_word, digest.digest_last);
                end
                else
                begin
                    wanted = expected_digests.pop_front();
                    checked++;
                    if (digest.digest_word !== wanted.digest_word
                        || digest.digest_last !== wanted.digest_last)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("sha1 check: digest word %0d: got %h last %b, want %h last %b",
                                     checked, digest.digest_word, digest.digest_last,
                                     wanted.digest_word, wanted.digest_last);
                    end
                end
            end

            // Absorb an accepted request; the sixteenth word closes the block.
            if (word_valid && word_ready)
            begin
                window[word_index] = word.data_word;
                if (word_index == LAST_WORD)
                begin
                    if (word.first_block)
                        for (idx = 0; idx < DIGEST_WORDS; idx++)
                            chain[idx] = INIT_HASH[idx];
                    compress_into_chain();
                    if (word.final_block)
                        for (idx = 0; idx < DIGEST_WORDS; idx++)
                        begin
                            wanted.digest_word = chain[idx];
                            wanted.digest_last = (idx == DIGEST_WORDS - 1);
                            expected_digests.push_back(wanted);
                        end
                end
                word_index = word_index + 1'b1;
            end

            fail_count <= failures;
            digests_pending <= expected_digests.size();
            digests_checked <= checked;
        end
    end

endmodule

### dv/tb_sha1_block_compression.sv
`timescale 1ns / 100ps

module tb_sha1_block_compression;
    import sha1c_pkg::*;

    localparam int unsigned RANDOM_BLOCKS = 24;
    localparam int unsigned QUIET_FIRST   = 10;
    localparam int unsigned QUIET_LAST    = 17;
    localparam int unsigned IDLE_PERCENT  = 11;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES  = 200;

    typedef enum int unsigned
    {
        FILL_ABC,
        FILL_ONES,
        FILL_ZEROS,
        FILL_SPARSE,
        FILL_RANDOM
    } fill_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       word_valid = 1'b0;
    logic       word_ready;
    sha1c_in_t  word = '0;
    logic       digest_valid;
    logic       digest_ready = 1'b0;
    sha1c_out_t digest;
    logic       quiet = 1'b0;

    int          fail_count;
    int          digests_pending;
    int          digests_checked;
    int unsigned words_sent = 0;
    int unsigned blocks_sent = 0;
    int unsigned first_blocks = 0;
    int unsigned final_blocks = 0;

    sha1_block_compression uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_ready   (word_ready),
        .word         (word),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    sha1_digest_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .word_valid      (word_valid),
        .word_ready      (word_ready),
        .word            (word),
        .digest_valid    (digest_valid),
        .digest_ready    (digest_ready),
        .digest          (digest),
        .fail_count      (fail_count),
        .digests_pending (digests_pending),
        .digests_checked (digests_checked)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // The digest consumer stalls at random outside the quiet stretch.
    always @(posedge clk)
        digest_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);

    // Present one request and hold it until accepted, with an occasional gap first.
    task automatic send_word(input logic [31:0] data, input logic first_flag,
                             input logic final_flag);
        while (!quiet && ($urandom_range(99) < IDLE_PERCENT))
        begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        word_valid <= 1'b1;
        word <= '{data_word: data, first_block: first_flag, final_block: final_flag};
        @(posedge clk);
        while (!word_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Send sixteen words; the flags only count on the last one.
    task automatic send_block(input fill_t fill, input logic first_flag,
                              input logic final_flag);
        logic [31:0] data;
        logic [1:0]  stray;
        int unsigned i;
        for (i = 0; i < BLOCK_WORDS; i++)
        begin
            case (fill)
                FILL_ABC:
                    data = (i == 0) ? 32'h61626380 : (i == BLOCK_WORDS - 1) ? 32'h18 : '0;
                FILL_ONES:
                    data = '1;
                FILL_ZEROS:
                    data = '0;
                FILL_SPARSE:
                    data = 32'h1 << $urandom_range(31);
                default:
                    data = $urandom;
            endcase
            // Flags on the earlier words must be ignored by the block.
            if (fill == FILL_ONES)
                stray = 2'b11;
            else if ($urandom_range(99) < 25)
                stray = 2'($urandom_range(3));
            else
                stray = 2'b00;
            if (i == BLOCK_WORDS - 1)
                send_word(data, first_flag, final_flag);
            else
                send_word(data, stray[1], stray[0]);
        end
        blocks_sent++;
        if (first_flag)
            first_blocks++;
        if (final_flag)
            final_blocks++;
    endtask

    // Stimulus: directed blocks, then random blocks, then drain and verdict.
    initial
    begin : stimulus
        int unsigned blk;
        int unsigned pick;
        fill_t       fill;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unflagged first block straight after reset starts from the initial values.
        send_block(FILL_ABC, 1'b0, 1'b1);
        // All-ones words with stray flags, chaining on from the digest just sent.
        send_block(FILL_ONES, 1'b0, 1'b1);

        for (blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            quiet <= (blk >= QUIET_FIRST) && (blk < QUIET_LAST);
            pick = $urandom_range(9);
            if (pick == 0)
                fill = FILL_ZEROS;
            else if (pick == 1)
                fill = FILL_ONES;
            else if (pick == 2)
                fill = FILL_SPARSE;
            else
                fill = FILL_RANDOM;
            send_block(fill, $urandom_range(99) < 40,
                       ($urandom_range(99) < 55) || (blk == RANDOM_BLOCKS - 1));
        end
        word_valid <= 1'b0;
        quiet <= 1'b0;

        @(posedge clk);
        while (digests_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d words in %0d blocks, %0d restarting and %0d emitting a digest.",
                 words_sent, blocks_sent, first_blocks, final_blocks);
        $display("Run: %0d digest words checked, %0d failures.", digests_checked, fail_count);
        if (fail_count == 0 && digests_pending == 0)
            $display("[sha1_block_compression] OK");
        else
            $display("[sha1_block_compression] ERROR");
        $finish;
    end

    // End the run if neither channel moves for too long.
    initial
    begin : watchdog
        int unsigned stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((word_valid && word_ready) || (digest_valid && digest_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("Watchdog: %0d cycles with no request and no digest word.", STALL_LIMIT);
        $display("[sha1_block_compression] ERROR");
        $finish;
    end

endmodule
